// ===== design/psl_pkg.sv =====
// ----------------------------------------------------------------------------
// psl_pkg: shared types and constants for the positional shift list
// Sizes, request codes and the control structs passed between modules.
// ----------------------------------------------------------------------------
package psl_pkg;

  localparam int CAPACITY   = 64;
  localparam int ENTRY_BITS = 12;
  localparam int REQ_W      = 3;
  localparam int POS_W      = 7;
  localparam int VAL_W      = 12;
  localparam int OUT_W      = 12;
  localparam int COUNT_W    = $clog2(CAPACITY + 1);

  typedef logic [ENTRY_BITS-1:0] entry_t;
  typedef logic [COUNT_W-1:0]    count_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_INS_FRONT = 3'd0,
    REQ_INS_POS   = 3'd1,
    REQ_INS_END   = 3'd2,
    REQ_REM_FRONT = 3'd3,
    REQ_REM_POS   = 3'd4,
    REQ_REM_END   = 3'd5,
    REQ_READ      = 3'd6
  } req_t;

  // decoded request; ins/rem/rd are already qualified by ok
  typedef struct packed {
    logic   ins;
    logic   rem;
    logic   rd;
    logic   ok;
    count_t pos;
  } list_cmd_t;

  // per-cell load select
  typedef struct packed {
    logic load;
    logic from_prev;
    logic from_next;
  } cell_ctl_t;

endpackage

// ===== design/psl_if.sv =====
// ----------------------------------------------------------------------------
// psl_if: valid/ready channels of the positional shift list
// Request channel and result channel, each with source and sink modports.
// ----------------------------------------------------------------------------
interface psl_in_if import psl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] entry_value;

  modport source (output valid, req_type, position, entry_value, input ready);
  modport sink   (input valid, req_type, position, entry_value, output ready);
endinterface

interface psl_out_if import psl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OUT_W-1:0]   entry_out;
  logic               entry_valid;
  logic               error;
  logic [COUNT_W-1:0] list_count;

  modport source (output valid, entry_out, entry_valid, error, list_count, input ready);
  modport sink   (input valid, entry_out, entry_valid, error, list_count, output ready);
endinterface

// ===== design/psl_ctrl.sv =====
// ----------------------------------------------------------------------------
// psl_ctrl: request decoder
// Resolves the target position of a request and checks it against the count.
// ----------------------------------------------------------------------------
module psl_ctrl import psl_pkg::*; (
  input  logic [REQ_W-1:0] req_type,
  input  logic [POS_W-1:0] position,
  input  count_t           count,
  output list_cmd_t        cmd
);

  logic   ins, rem, rd, ok;
  count_t pos, pos_in;

  assign pos_in = count_t'(position);

  always_comb begin
    ins = 1'b0;
    rem = 1'b0;
    rd  = 1'b0;
    pos = '0;
    unique case (req_t'(req_type))
      REQ_INS_FRONT: begin ins = 1'b1; pos = '0;                end
      REQ_INS_POS:   begin ins = 1'b1; pos = pos_in;            end
      REQ_INS_END:   begin ins = 1'b1; pos = count;             end
      REQ_REM_FRONT: begin rem = 1'b1; pos = '0;                end
      REQ_REM_POS:   begin rem = 1'b1; pos = pos_in;            end
      // empty list wraps to all ones, which fails the range check
      REQ_REM_END:   begin rem = 1'b1; pos = count - 1'b1;      end
      REQ_READ:      begin rd  = 1'b1; pos = pos_in;            end
      default:       begin ins = 1'b0;                          end
    endcase
  end

  always_comb begin
    if (ins) begin
      ok = (count < count_t'(CAPACITY)) && (pos <= count);
    end else if (rem || rd) begin
      ok = pos < count;
    end else begin
      ok = 1'b0;
    end
  end

  assign cmd.ins = ins & ok;
  assign cmd.rem = rem & ok;
  assign cmd.rd  = rd & ok;
  assign cmd.ok  = ok;
  assign cmd.pos = pos;

endmodule

// ===== design/psl_cell.sv =====
// ----------------------------------------------------------------------------
// psl_cell: one list slot
// Holds one entry; loads a new value or takes its neighbor's on a shift.
// ----------------------------------------------------------------------------
module psl_cell import psl_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    load_val,
  input  entry_t    prev_val,
  input  entry_t    next_val,
  output entry_t    val
);

  entry_t val_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val_r <= load_val;
    end else if (ctl.from_prev) begin
      val_r <= prev_val;
    end else if (ctl.from_next) begin
      val_r <= next_val;
    end
  end

  assign val = val_r;

endmodule

// ===== design/positional_shift_list.sv =====
// ----------------------------------------------------------------------------
// positional_shift_list: ordered list with positional insert and remove
// A row of slot cells shifts the entries at and after the target place by one.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  in_ch   | in  | req_type, position, entry_value
//  out_ch  | out | entry_out, entry_valid, error, list_count
//
//  One request per clock while the output register can drain: the cells at and
//  after the target position shift or load in the cycle of the beat, and the result is held in an output register.
//  A new request beat is taken whenever that register is empty or drained.
//  Reset clears the count and the output valid; slot contents stay undefined.
// ----------------------------------------------------------------------------
module positional_shift_list import psl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  psl_in_if.sink    in_ch,
  psl_out_if.source out_ch
);

  count_t           count_r, count_nxt;
  logic             out_valid_r;
  logic [OUT_W-1:0] entry_out_r;
  logic             entry_valid_r;
  logic             error_r;
  count_t           list_count_r;
  logic             in_fire;
  list_cmd_t        cmd;
  entry_t           ins_val;
  entry_t           cell_q   [CAPACITY];
  entry_t           cell_sel [CAPACITY];
  entry_t           sel_data;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign ins_val     = entry_t'(in_ch.entry_value);

  psl_ctrl u_ctrl (
    .req_type (in_ch.req_type),
    .position (in_ch.position),
    .count    (count_r),
    .cmd      (cmd)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    prev_v, next_v;

    assign ctl.load      = in_fire && cmd.ins && (cmd.pos == count_t'(i));
    assign ctl.from_prev = in_fire && cmd.ins && (count_t'(i) > cmd.pos);
    assign ctl.from_next = in_fire && cmd.rem && (count_t'(i) >= cmd.pos);

    if (i == 0) begin : g_head
      assign prev_v = cell_q[i];
    end else begin : g_body
      assign prev_v = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_v = cell_q[i];
    end else begin : g_link
      assign next_v = cell_q[i+1];
    end

    psl_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .load_val (ins_val),
      .prev_val (prev_v),
      .next_val (next_v),
      .val      (cell_q[i])
    );

    assign cell_sel[i] = (cmd.pos == count_t'(i)) ? cell_q[i] : '0;
  end

  // one-hot AND-OR pick of the addressed slot
  always_comb begin
    sel_data = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      sel_data = sel_data | cell_sel[k];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (in_fire && cmd.ins) begin
      count_nxt = count_r + 1'b1;
    end else if (in_fire && cmd.rem) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      entry_out_r   <= (cmd.rem || cmd.rd) ? OUT_W'(sel_data) : '0;
      entry_valid_r <= cmd.rem || cmd.rd;
      error_r       <= !cmd.ok;
      list_count_r  <= count_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.entry_out   = entry_out_r;
  assign out_ch.entry_valid = entry_valid_r;
  assign out_ch.error       = error_r;
  assign out_ch.list_count  = list_count_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= count_t'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && cmd.ins |=> count_r == $past(count_r) + 1'b1)
    else $error("accepted insert did not grow the list");

  a_err_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && error_r |-> !entry_valid_r && list_count_r == count_r)
    else $error("refused request changed the list or returned an entry");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for positional_shift_list
// Drives list requests through the valid/ready input channel, keeps a shadow
// copy of the list to predict every result beat, and compares each result
// field by field. Runs directed corner cases, a fill-to-capacity pass, a long
// receiver hold-off and random traffic under several idling mixes.
// ----------------------------------------------------------------------------
module tb;
  import psl_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 480;

  typedef struct packed {
    logic [OUT_W-1:0] entry_out;
    logic             entry_valid;
    logic             error;
    count_t           list_count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n;

  psl_in_if  in_ch ();
  psl_out_if out_ch ();

  positional_shift_list uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the list contents, updated at each accepted request beat
  entry_t       shadow_list [CAPACITY];
  int           shadow_count;
  list_result_t expected_results [$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int mismatch_count;
  int cycle_count;

  // ---------------------------------------------------------------- predictor
  function automatic bit list_insert(input int at, input logic [VAL_W-1:0] v);
    if (shadow_count >= CAPACITY || at > shadow_count) return 1'b0;
    for (int i = shadow_count; i > at; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[at] = entry_t'(v);
    shadow_count++;
    return 1'b1;
  endfunction

  function automatic bit list_remove(input int at, output entry_t v);
    v = '0;
    if (at >= shadow_count) return 1'b0;
    v = shadow_list[at];
    for (int i = at; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
    shadow_count--;
    return 1'b1;
  endfunction

  function automatic list_result_t apply_request(input logic [REQ_W-1:0] req,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [VAL_W-1:0] val);
    list_result_t r;
    entry_t       taken;
    bit           ok;
    bit           has_entry;
    ok        = 1'b0;
    has_entry = 1'b0;
    taken     = '0;
    case (req)
      REQ_INS_FRONT: ok = list_insert(0, val);
      REQ_INS_POS:   ok = list_insert(int'(pos), val);
      REQ_INS_END:   ok = list_insert(shadow_count, val);
      REQ_REM_FRONT: begin
        ok = list_remove(0, taken);
        has_entry = ok;
      end
      REQ_REM_POS: begin
        ok = list_remove(int'(pos), taken);
        has_entry = ok;
      end
      REQ_REM_END: begin
        if (shadow_count > 0) begin
          ok = list_remove(shadow_count - 1, taken);
          has_entry = ok;
        end
      end
      REQ_READ: begin
        if (int'(pos) < shadow_count) begin
          taken = shadow_list[pos];
          ok = 1'b1;
          has_entry = 1'b1;
        end
      end
      default: ok = 1'b0;
    endcase
    r.entry_out   = has_entry ? taken : '0;
    r.entry_valid = has_entry;
    r.error       = !ok;
    r.list_count  = count_t'(shadow_count);
    return r;
  endfunction

  // --------------------------------------------------------------- driving
  task automatic send_request(input logic [REQ_W-1:0] req,
                              input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= req;
    in_ch.position    <= pos;
    in_ch.entry_value <= val;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    // beat taken at this edge; predict now so the next pick sees the new count
    expected_results.push_back(apply_request(req, pos, val));
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    return VAL_W'($urandom);
  endfunction

  // grow biases toward inserts so the list swings between empty and full
  task automatic send_random_request(input bit grow);
    int                 r;
    int                 pos_max;
    logic [REQ_W-1:0]   req;
    logic [POS_W-1:0]   pos;
    r = $urandom_range(99);
    if (r < 3) req = REQ_UNUSED;
    else if (r < 15) req = REQ_READ;
    else if (r < (grow ? 72 : 38)) req = REQ_W'($urandom_range(REQ_INS_END, REQ_INS_FRONT));
    else req = REQ_W'($urandom_range(REQ_REM_END, REQ_REM_FRONT));
    pos_max = (req inside {REQ_INS_FRONT, REQ_INS_POS, REQ_INS_END}) ?
              shadow_count : shadow_count - 1;
    r = $urandom_range(99);
    if (r < 85 && pos_max >= 0) pos = POS_W'($urandom_range(pos_max));
    else if (r < 95) pos = POS_W'($urandom_range(CAPACITY));
    else pos = POS_W'($urandom);
    send_request(req, pos, pick_value());
  endtask

  // --------------------------------------------------------------- receiver
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------- checking
  always @(posedge clk) begin : check_results
    list_result_t exp_r;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no request outstanding");
        mismatch_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_ch.entry_out !== exp_r.entry_out) begin
          $error("entry_out: expected %0d, got %0d", exp_r.entry_out, out_ch.entry_out);
          mismatch_count++;
        end
        if (out_ch.entry_valid !== exp_r.entry_valid) begin
          $error("entry_valid: expected %0d, got %0d",
                 exp_r.entry_valid, out_ch.entry_valid);
          mismatch_count++;
        end
        if (out_ch.error !== exp_r.error) begin
          $error("error: expected %0d, got %0d", exp_r.error, out_ch.error);
          mismatch_count++;
        end
        if (out_ch.list_count !== exp_r.list_count) begin
          $error("list_count: expected %0d, got %0d",
                 exp_r.list_count, out_ch.list_count);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------- tests
  task automatic test_directed_cases();
    // empty list: every remove and read is refused
    send_request(REQ_REM_FRONT, 7'd0, pick_value());
    send_request(REQ_REM_POS, 7'd0, pick_value());
    send_request(REQ_REM_END, 7'd0, pick_value());
    send_request(REQ_READ, 7'd0, pick_value());
    send_request(REQ_INS_POS, 7'd1, 12'h123);
    send_request(REQ_INS_FRONT, 7'd0, 12'h000);
    send_request(REQ_INS_END, 7'd0, 12'hFFF);
    send_request(REQ_INS_POS, 7'd1, 12'hA5A);
    send_request(REQ_INS_POS, 7'd3, 12'h5A5);   // position equal to count
    send_request(REQ_INS_POS, 7'd5, 12'h777);   // beyond count
    for (int i = 0; i < 5; i++) send_request(REQ_READ, POS_W'(i), pick_value());
    send_request(REQ_READ, 7'd64, pick_value());
    send_request(REQ_READ, 7'd127, pick_value());
    send_request(REQ_UNUSED, 7'd0, 12'hFFF);
    send_request(REQ_REM_POS, 7'd1, pick_value());
    send_request(REQ_REM_POS, 7'd3, pick_value());
    send_request(REQ_REM_END, 7'd127, pick_value());
    send_request(REQ_REM_FRONT, 7'd64, pick_value());
    send_request(REQ_REM_POS, 7'd0, pick_value());
  endtask

  task automatic test_full_list();
    while (shadow_count < CAPACITY)
      send_request(REQ_W'($urandom_range(REQ_INS_END, REQ_INS_FRONT)),
                   POS_W'($urandom_range(shadow_count)), pick_value());
    // full: every insert is refused until a remove frees a slot
    send_request(REQ_INS_FRONT, 7'd0, pick_value());
    send_request(REQ_INS_POS, 7'd64, pick_value());
    send_request(REQ_INS_POS, 7'd10, pick_value());
    send_request(REQ_INS_END, 7'd0, pick_value());
    send_request(REQ_READ, 7'd63, pick_value());
    send_request(REQ_READ, 7'd64, pick_value());
    send_request(REQ_REM_POS, 7'd63, pick_value());
    send_request(REQ_INS_POS, 7'd63, 12'hFFF);
    send_request(REQ_REM_POS, 7'd64, pick_value());
    while (shadow_count > 0)
      send_request(REQ_W'($urandom_range(REQ_REM_END, REQ_REM_FRONT)),
                   POS_W'($urandom_range(shadow_count - 1)), pick_value());
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = 200;
    for (int i = 0; i < 40; i++) send_random_request(1'b1);
  endtask

  task automatic test_random_traffic(input int sender_idle, input int receiver_idle);
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    for (int i = 0; i < PHASE_ITEMS; i++) send_random_request(((i / 80) % 2) == 0);
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.req_type    = '0;
    in_ch.position    = '0;
    in_ch.entry_value = '0;
    out_ch.ready      = 1'b0;
    shadow_count      = 0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    hold_cycles       = 0;
    mismatch_count    = 0;
    cycle_count       = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_full_list();
    test_output_backpressure();
    test_random_traffic(20, 85);
    test_random_traffic(85, 20);
    test_random_traffic(0, 0);
    in_ch.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
